/* hw/rtl/y86ie_pkg.sv */
// Package for the Y86-64 instruction executor: memory size, register ids,
// status codes, instruction codes and the decode helper functions.
// No dependencies.
package y86ie_pkg;

  localparam int unsigned MEM_BYTES = 8192;
  localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);
  localparam logic [63:0] MEM_LAST_WORD = 64'(MEM_BYTES - 8);

  localparam logic [3:0] REG_NONE = 4'hf;
  localparam logic [3:0] REG_RSP  = 4'd4;

  localparam logic [1:0] ST_AOK = 2'd0;
  localparam logic [1:0] ST_HLT = 2'd1;
  localparam logic [1:0] ST_ADR = 2'd2;
  localparam logic [1:0] ST_INS = 2'd3;

  localparam logic [3:0] I_HALT  = 4'd0;
  localparam logic [3:0] I_NOP   = 4'd1;
  localparam logic [3:0] I_CMOV  = 4'd2;
  localparam logic [3:0] I_IRMOV = 4'd3;
  localparam logic [3:0] I_RMMOV = 4'd4;
  localparam logic [3:0] I_MRMOV = 4'd5;
  localparam logic [3:0] I_OPQ   = 4'd6;
  localparam logic [3:0] I_JXX   = 4'd7;
  localparam logic [3:0] I_CALL  = 4'd8;
  localparam logic [3:0] I_RET   = 4'd9;
  localparam logic [3:0] I_PUSH  = 4'd10;
  localparam logic [3:0] I_POP   = 4'd11;

  localparam logic [1:0] ALU_ADD = 2'd0;
  localparam logic [1:0] ALU_SUB = 2'd1;
  localparam logic [1:0] ALU_AND = 2'd2;

  // instruction length in bytes
  function automatic logic [3:0] ilen(input logic [3:0] ic);
    logic [3:0] n;
    case (ic)
      I_CMOV, I_OPQ, I_PUSH, I_POP:   n = 4'd2;
      I_IRMOV, I_RMMOV, I_MRMOV:      n = 4'd10;
      I_JXX, I_CALL:                  n = 4'd9;
      default:                        n = 4'd1;
    endcase
    return n;
  endfunction

  // largest legal function code
  function automatic logic [3:0] fmax(input logic [3:0] ic);
    logic [3:0] n;
    case (ic)
      I_CMOV, I_JXX: n = 4'd6;
      I_OPQ:         n = 4'd3;
      default:       n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic cond(input logic [3:0] f, input logic zf, input logic sf,
                                input logic of);
    logic lt;
    logic c;
    lt = sf ^ of;
    case (f)
      4'd0:    c = 1'b1;
      4'd1:    c = lt | zf;
      4'd2:    c = lt;
      4'd3:    c = zf;
      4'd4:    c = ~zf;
      4'd5:    c = ~lt;
      4'd6:    c = ~lt & ~zf;
      default: c = 1'b0;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/y86_instruction_executor_core.sv */
// Sequential Y86-64 core: byte memory, register file, fetch/execute sequencer.
// Depends on y86ie_pkg.
//
// Each input transfer is either a load (kind 0: write one memory byte) or a
// step (kind 1: run one instruction); each gives exactly one result transfer.
// A load, or a step while stopped, finishes in the idle state that takes it.
// A step moves through the byte-wide memory ports one byte a cycle: it fetches
// the opcode byte and then the other len - 1 bytes (len 1..10), does three
// register-file reads through its one read port and an execute state, and
// for memory instructions an address check plus eight data bytes (popq
// adds a state for its second register write). A new transfer is taken
// only in idle, while the result register is empty or is drained at the same
// edge; a result left waiting holds off the input. Memory contents are
// undefined until written; the register file reads zero until written.
module y86_instruction_executor_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [12:0]        load_address_i,
  input  logic [7:0]         load_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [12:0]        instr_pc_o,
  output logic [3:0]         icode_o,
  output logic [3:0]         ifun_o,
  output logic [1:0]         status_o,
  output logic               zero_flag_o,
  output logic               sign_flag_o,
  output logic               overflow_flag_o,
  output logic               reg_written_o,
  output logic [3:0]         reg_index_o,
  output logic signed [63:0] reg_value_o
);

  localparam int unsigned AW = y86ie_pkg::MEM_AW;

  typedef enum logic [3:0] {
    S_IDLE, S_F1, S_FB, S_RA, S_RB, S_RS, S_EX, S_AC, S_ST, S_LD, S_P2
  } state_e;

  state_e      state_q, state_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] pc_q, pc_d;
  logic [1:0]  stat_q, stat_d;
  logic        zf_q, zf_d, sf_q, sf_d, of_q, of_d;
  logic [3:0]  icode_q, icode_d, ifun_q, ifun_d, ra_q, ra_d, rb_q, rb_d, len_q, len_d;
  logic [63:0] valc_q, valc_d, x_q, x_d, y_q, y_d, addr_q, addr_d, dat_q, dat_d;

  // result register
  logic        ov_q, ov_d;
  logic [12:0] o_pc_q, o_pc_d;
  logic [3:0]  o_ic_q, o_ic_d, o_if_q, o_if_d, o_idx_q, o_idx_d;
  logic [1:0]  o_st_q, o_st_d;
  logic        o_z_q, o_z_d, o_s_q, o_s_d, o_o_q, o_o_d, o_wr_q, o_wr_d;
  logic [63:0] o_val_q, o_val_d;

  // memories
  logic [7:0]  mem [y86ie_pkg::MEM_BYTES];
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]  mem_wd, mem_rd_q;

  logic [63:0] rf [15];
  logic [14:0] rf_vld_q;
  logic        rf_we, rf_re;
  logic [3:0]  rf_wa, rf_ra;
  logic [63:0] rf_wd, rf_rd_q;
  logic        rf_rv_q;
  logic [63:0] rfval;

  // finish request
  logic        fin, fwr;
  logic [3:0]  fidx;
  logic [63:0] fval;

  logic        accept;
  logic [63:0] valp, alu_r, ld_word;
  logic [7:0]  b;
  logic        ok_c;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE) && (!ov_q || out_ready_i);
  assign rfval = rf_rv_q ? rf_rd_q : 64'd0;
  assign valp = pc_q + 64'(len_q);
  assign b = mem_rd_q;
  assign ld_word = {mem_rd_q, dat_q[63:8]};
  assign ok_c = y86ie_pkg::cond(ifun_q, zf_q, sf_q, of_q);

  always_comb begin
    case (ifun_q[1:0])
      y86ie_pkg::ALU_ADD: alu_r = y_q + x_q;
      y86ie_pkg::ALU_SUB: alu_r = y_q - x_q;
      y86ie_pkg::ALU_AND: alu_r = y_q & x_q;
      default:            alu_r = y_q ^ x_q;
    endcase
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; pc_d = pc_q; stat_d = stat_q;
    zf_d = zf_q; sf_d = sf_q; of_d = of_q;
    icode_d = icode_q; ifun_d = ifun_q; ra_d = ra_q; rb_d = rb_q; len_d = len_q;
    valc_d = valc_q; x_d = x_q; y_d = y_q; addr_d = addr_q; dat_d = dat_q;
    mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_re = 1'b0; mem_ra = '0;
    rf_we = 1'b0; rf_wa = '0; rf_wd = '0; rf_re = 1'b0; rf_ra = '0;
    fin = 1'b0; fwr = 1'b0; fidx = '0; fval = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          icode_d = 4'd0;
          ifun_d  = 4'd0;
          if (!kind_i) begin
            if (64'(load_address_i) < 64'(y86ie_pkg::MEM_BYTES)) begin
              mem_we = 1'b1;
              mem_wa = AW'(64'(load_address_i));
              mem_wd = load_byte_i;
            end
            fin = 1'b1;
          end else if (stat_q != y86ie_pkg::ST_AOK) begin
            fin = 1'b1;
          end else if (pc_q >= 64'(y86ie_pkg::MEM_BYTES)) begin
            stat_d = y86ie_pkg::ST_ADR;
            fin = 1'b1;
          end else begin
            mem_re = 1'b1;
            mem_ra = pc_q[AW-1:0];
            state_d = S_F1;
          end
        end
      end
      S_F1: begin
        icode_d = b[7:4];
        ifun_d  = b[3:0];
        len_d   = y86ie_pkg::ilen(b[7:4]);
        ra_d = y86ie_pkg::REG_NONE;
        rb_d = y86ie_pkg::REG_NONE;
        valc_d = '0;
        if (b[7:4] > y86ie_pkg::I_POP || b[3:0] > y86ie_pkg::fmax(b[7:4])) begin
          stat_d = y86ie_pkg::ST_INS;
          fin = 1'b1;
        end else if (pc_q + 64'(len_d) > 64'(y86ie_pkg::MEM_BYTES)) begin
          stat_d = y86ie_pkg::ST_ADR;
          fin = 1'b1;
        end else if (len_d == 4'd1) begin
          state_d = S_RA;
        end else begin
          mem_re = 1'b1;
          mem_ra = pc_q[AW-1:0] + AW'(1);
          cnt_d = 4'd1;
          state_d = S_FB;
        end
      end
      S_FB: begin
        if (cnt_q == 4'd1 && len_q != 4'd9) begin
          ra_d = b[7:4];
          rb_d = b[3:0];
        end else begin
          valc_d = {b, valc_q[63:8]};
        end
        if (cnt_q == len_q - 4'd1) begin
          state_d = S_RA;
        end else begin
          mem_re = 1'b1;
          mem_ra = pc_q[AW-1:0] + AW'(cnt_q) + AW'(1);
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_RA: begin
        rf_re = 1'b1; rf_ra = ra_q; state_d = S_RB;
      end
      S_RB: begin
        x_d = rfval; rf_re = 1'b1; rf_ra = rb_q; state_d = S_RS;
      end
      S_RS: begin
        y_d = rfval; rf_re = 1'b1; rf_ra = y86ie_pkg::REG_RSP; state_d = S_EX;
      end
      S_EX: begin
        unique case (icode_q)
          y86ie_pkg::I_HALT: begin
            stat_d = y86ie_pkg::ST_HLT; fin = 1'b1;
          end
          y86ie_pkg::I_NOP: begin
            pc_d = valp; fin = 1'b1;
          end
          y86ie_pkg::I_CMOV: begin
            fwr = ok_c; fidx = rb_q; fval = x_q; pc_d = valp; fin = 1'b1;
          end
          y86ie_pkg::I_IRMOV: begin
            fwr = 1'b1; fidx = rb_q; fval = valc_q; pc_d = valp; fin = 1'b1;
          end
          y86ie_pkg::I_OPQ: begin
            zf_d = (alu_r == 64'd0);
            sf_d = alu_r[63];
            case (ifun_q[1:0])
              y86ie_pkg::ALU_ADD: of_d = (~(x_q[63] ^ y_q[63])) & (alu_r[63] ^ y_q[63]);
              y86ie_pkg::ALU_SUB: of_d = (x_q[63] ^ y_q[63]) & (alu_r[63] ^ y_q[63]);
              default:            of_d = 1'b0;
            endcase
            fwr = 1'b1; fidx = rb_q; fval = alu_r; pc_d = valp; fin = 1'b1;
          end
          y86ie_pkg::I_JXX: begin
            pc_d = ok_c ? valc_q : valp; fin = 1'b1;
          end
          y86ie_pkg::I_RMMOV, y86ie_pkg::I_MRMOV: begin
            addr_d = valc_q + y_q; dat_d = x_q; state_d = S_AC;
          end
          y86ie_pkg::I_CALL: begin
            addr_d = rfval - 64'd8; dat_d = valp; state_d = S_AC;
          end
          y86ie_pkg::I_PUSH: begin
            addr_d = rfval - 64'd8; dat_d = x_q; state_d = S_AC;
          end
          default: begin
            addr_d = rfval; state_d = S_AC;
          end
        endcase
      end
      S_AC: begin
        cnt_d = 4'd0;
        if (addr_q > y86ie_pkg::MEM_LAST_WORD) begin
          stat_d = y86ie_pkg::ST_ADR; fin = 1'b1;
        end else if (icode_q == y86ie_pkg::I_RMMOV || icode_q == y86ie_pkg::I_CALL ||
                     icode_q == y86ie_pkg::I_PUSH) begin
          state_d = S_ST;
        end else begin
          mem_re = 1'b1; mem_ra = addr_q[AW-1:0]; state_d = S_LD;
        end
      end
      S_ST: begin
        mem_we = 1'b1;
        mem_wa = addr_q[AW-1:0] + AW'(cnt_q);
        mem_wd = dat_q[7:0];
        dat_d = {8'd0, dat_q[63:8]};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd7) begin
          fin = 1'b1;
          if (icode_q == y86ie_pkg::I_RMMOV) begin
            pc_d = valp;
          end else begin
            fwr = 1'b1; fidx = y86ie_pkg::REG_RSP; fval = addr_q;
            pc_d = (icode_q == y86ie_pkg::I_CALL) ? valc_q : valp;
          end
        end
      end
      S_LD: begin
        dat_d = ld_word;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q != 4'd7) begin
          mem_re = 1'b1;
          mem_ra = addr_q[AW-1:0] + AW'(cnt_q) + AW'(1);
        end else begin
          case (icode_q)
            y86ie_pkg::I_MRMOV: begin
              fwr = 1'b1; fidx = ra_q; fval = ld_word; pc_d = valp; fin = 1'b1;
            end
            y86ie_pkg::I_RET: begin
              fwr = 1'b1; fidx = y86ie_pkg::REG_RSP; fval = addr_q + 64'd8;
              pc_d = ld_word; fin = 1'b1;
            end
            default: begin
              rf_we = 1'b1; rf_wa = y86ie_pkg::REG_RSP; rf_wd = addr_q + 64'd8;
              state_d = S_P2;
            end
          endcase
        end
      end
      S_P2: begin
        fwr = 1'b1;
        if (ra_q != y86ie_pkg::REG_NONE) begin
          fidx = ra_q; fval = dat_q;
        end else begin
          fidx = y86ie_pkg::REG_RSP; fval = addr_q + 64'd8;
        end
        pc_d = valp; fin = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase

    // drop writes to the none register id
    if (fidx == y86ie_pkg::REG_NONE) fwr = 1'b0;
    if (fwr) begin
      rf_we = 1'b1; rf_wa = fidx; rf_wd = fval;
    end

    ov_d = ov_q && !out_ready_i;
    o_pc_d = o_pc_q; o_ic_d = o_ic_q; o_if_d = o_if_q; o_st_d = o_st_q;
    o_z_d = o_z_q; o_s_d = o_s_q; o_o_d = o_o_q;
    o_wr_d = o_wr_q; o_idx_d = o_idx_q; o_val_d = o_val_q;
    if (fin) begin
      state_d = S_IDLE;
      ov_d = 1'b1;
      o_pc_d = pc_q[12:0];
      o_ic_d = icode_d; o_if_d = ifun_d; o_st_d = stat_d;
      o_z_d = zf_d; o_s_d = sf_d; o_o_d = of_d;
      o_wr_d = fwr;
      o_idx_d = fwr ? fidx : 4'd0;
      o_val_d = fwr ? fval : 64'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0; pc_q <= '0; stat_q <= y86ie_pkg::ST_AOK;
      zf_q <= 1'b0; sf_q <= 1'b0; of_q <= 1'b0;
      ov_q <= 1'b0;
      o_pc_q <= '0; o_ic_q <= '0; o_if_q <= '0; o_st_q <= y86ie_pkg::ST_AOK;
      o_z_q <= 1'b0; o_s_q <= 1'b0; o_o_q <= 1'b0;
      o_wr_q <= 1'b0; o_idx_q <= '0; o_val_q <= '0;
      rf_vld_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d; pc_q <= pc_d; stat_q <= stat_d;
      zf_q <= zf_d; sf_q <= sf_d; of_q <= of_d;
      ov_q <= ov_d;
      o_pc_q <= o_pc_d; o_ic_q <= o_ic_d; o_if_q <= o_if_d; o_st_q <= o_st_d;
      o_z_q <= o_z_d; o_s_q <= o_s_d; o_o_q <= o_o_d;
      o_wr_q <= o_wr_d; o_idx_q <= o_idx_d; o_val_q <= o_val_d;
      if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    icode_q <= icode_d; ifun_q <= ifun_d; ra_q <= ra_d; rb_q <= rb_d; len_q <= len_d;
    valc_q <= valc_d; x_q <= x_d; y_q <= y_d; addr_q <= addr_d; dat_q <= dat_d;
  end

  // byte memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_rd_q <= mem[mem_ra];
  end

  // register file; unwritten entries read as zero via valid bits
  always_ff @(posedge clk_i) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    if (rf_re) begin
      if (rf_ra != y86ie_pkg::REG_NONE) begin
        rf_rd_q <= rf[rf_ra];
        rf_rv_q <= rf_vld_q[rf_ra];
      end else begin
        rf_rd_q <= '0;
        rf_rv_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = ov_q;
  assign instr_pc_o      = o_pc_q;
  assign icode_o         = o_ic_q;
  assign ifun_o          = o_if_q;
  assign status_o        = o_st_q;
  assign zero_flag_o     = o_z_q;
  assign sign_flag_o     = o_s_q;
  assign overflow_flag_o = o_o_q;
  assign reg_written_o   = o_wr_q;
  assign reg_index_o     = o_idx_q;
  assign reg_value_o     = signed'(o_val_q);

  a_stat_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_q != y86ie_pkg::ST_AOK |=> stat_q == $past(stat_q))
    else $error("machine status left a stopped state");

  a_mem_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> 64'(mem_ra) < 64'(y86ie_pkg::MEM_BYTES))
    else $error("memory read outside the array");

  a_rf_no_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> rf_wa != y86ie_pkg::REG_NONE)
    else $error("register write to the none id");

  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) && !fin |=> !ov_q || $past(ov_q))
    else $error("result raised without finishing a transfer");

endmodule

/* tb/sv/tb_top.sv */
// Testbench for y86_instruction_executor_core: builds Y86-64 programs byte by byte
// through load transfers, steps them, and checks every result against a local predictor.
// Depends on y86ie_pkg and the core RTL.
module tb_top;

  // function codes used by the stimulus and the predictor
  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_AND = 4'd2;
  localparam logic [3:0] OP_XOR = 4'd3;
  localparam logic [3:0] CC_ALW = 4'd0;
  localparam logic [3:0] CC_LE  = 4'd1;
  localparam logic [3:0] CC_L   = 4'd2;
  localparam logic [3:0] CC_E   = 4'd3;
  localparam logic [3:0] CC_NE  = 4'd4;
  localparam logic [3:0] CC_GE  = 4'd5;
  localparam logic [3:0] CC_G   = 4'd6;
  localparam bit KIND_LOAD = 1'b0;
  localparam bit KIND_STEP = 1'b1;

  // code lives low, data and stack high
  localparam int unsigned CODE_TOP  = 3900;
  localparam int unsigned DATA_LO   = 4096;
  localparam int unsigned STACK_LO  = 4200;

  typedef struct {
    logic [12:0] pc;
    logic [3:0]  icode;
    logic [3:0]  ifun;
    logic [1:0]  status;
    logic        zf, sf, of, wr;
    logic [3:0]  idx;
    logic [63:0] val;
  } y86_result_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, kind_i;
  logic [12:0] load_address_i;
  logic [7:0] load_byte_i;
  logic out_valid_o, out_ready_i;
  logic [12:0] instr_pc_o;
  logic [3:0] icode_o, ifun_o;
  logic [1:0] status_o;
  logic zero_flag_o, sign_flag_o, overflow_flag_o, reg_written_o;
  logic [3:0] reg_index_o;
  logic signed [63:0] reg_value_o;

  y86_instruction_executor_core u_top (.*);

  // predicted machine state
  logic [7:0]  mem_m [y86ie_pkg::MEM_BYTES];
  bit          known_m [y86ie_pkg::MEM_BYTES];
  logic [63:0] rf_m [15];
  logic [63:0] pc_m;
  logic        zf_m, sf_m, of_m;
  logic [1:0]  st_m;
  logic [12:0] touched_q[$];     // bytes a step would read
  y86_result_t pending_q[$];     // results owed by the core

  int errors;
  int snd_idle, rcv_idle;
  int hold_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #8000000;
    $display("tb_top: done, errors");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic int ins_len(input logic [3:0] ic);
    case (ic)
      y86ie_pkg::I_CMOV, y86ie_pkg::I_OPQ, y86ie_pkg::I_PUSH, y86ie_pkg::I_POP: return 2;
      y86ie_pkg::I_IRMOV, y86ie_pkg::I_RMMOV, y86ie_pkg::I_MRMOV:              return 10;
      y86ie_pkg::I_JXX, y86ie_pkg::I_CALL:                                      return 9;
      default:                                                                  return 1;
    endcase
  endfunction

  function automatic logic [3:0] fn_limit(input logic [3:0] ic);
    case (ic)
      y86ie_pkg::I_CMOV, y86ie_pkg::I_JXX: return CC_G;
      y86ie_pkg::I_OPQ:                    return OP_XOR;
      default:                             return 4'd0;
    endcase
  endfunction

  function automatic bit cc_holds(input logic [3:0] f, input logic z, input logic s,
                                  input logic o);
    logic lt;
    lt = s ^ o;
    case (f)
      CC_ALW:  return 1'b1;
      CC_LE:   return lt | z;
      CC_L:    return lt;
      CC_E:    return z;
      CC_NE:   return !z;
      CC_GE:   return !lt;
      CC_G:    return !lt && !z;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit in_range(input logic [63:0] a, input logic [63:0] n);
    return a < 64'(y86ie_pkg::MEM_BYTES) && n <= 64'(y86ie_pkg::MEM_BYTES) - a;
  endfunction

  function automatic logic [63:0] reg_rd(input logic [3:0] r);
    return (r < 4'd15) ? rf_m[r] : 64'd0;
  endfunction

  function automatic logic [7:0] rd_byte(input logic [63:0] a);
    touched_q.push_back(a[12:0]);
    return mem_m[a[12:0]];
  endfunction

  function automatic logic [63:0] rd_word(input logic [63:0] a);
    logic [63:0] v;
    v = '0;
    for (int k = 7; k >= 0; k--) v = (v << 8) | 64'(rd_byte(a + 64'(k)));
    return v;
  endfunction

  // one item through the machine; state is changed only when commit is set
  function automatic void y86_predict(input bit kind, input logic [12:0] la,
                                      input logic [7:0] lb, input bit commit,
                                      output y86_result_t res);
    logic [63:0] pc0, valc, valp, addr, x, y, r, rsp_new, wval, mw_addr, mw_val;
    logic [7:0] b;
    logic [3:0] ic, fn, ra, rb, widx;
    logic [1:0] st;
    logic z, s, o;
    bit wr, rsp_w, mw;
    int len;
    pc0 = pc_m; st = st_m; z = zf_m; s = sf_m; o = of_m;
    ic = '0; fn = '0; wr = 0; widx = '0; wval = '0; mw = 0; rsp_w = 0;
    mw_addr = '0; mw_val = '0; rsp_new = '0;
    if (kind == KIND_LOAD) begin
      if (commit) begin
        mem_m[la] = lb;
        known_m[la] = 1'b1;
      end
    end else if (st == y86ie_pkg::ST_AOK) begin
      if (!in_range(pc0, 1)) begin
        st = y86ie_pkg::ST_ADR;
      end else begin
        b = rd_byte(pc0);
        ic = b[7:4];
        fn = b[3:0];
        len = ins_len(ic);
        if (ic > y86ie_pkg::I_POP || fn > fn_limit(ic)) begin
          st = y86ie_pkg::ST_INS;
        end else if (!in_range(pc0, 64'(len))) begin
          st = y86ie_pkg::ST_ADR;
        end else begin
          ra = y86ie_pkg::REG_NONE; rb = y86ie_pkg::REG_NONE; valc = '0;
          valp = pc0 + 64'(len);
          if (len == 2 || len == 10) begin
            b = rd_byte(pc0 + 1);
            ra = b[7:4];
            rb = b[3:0];
          end
          if (len == 10) valc = rd_word(pc0 + 2);
          if (len == 9) valc = rd_word(pc0 + 1);
          case (ic)
            y86ie_pkg::I_HALT: begin
              st = y86ie_pkg::ST_HLT;
              valp = pc0;
            end
            y86ie_pkg::I_CMOV: if (cc_holds(fn, z, s, o)) begin
              wr = 1; widx = rb; wval = reg_rd(ra);
            end
            y86ie_pkg::I_IRMOV: begin
              wr = 1; widx = rb; wval = valc;
            end
            y86ie_pkg::I_RMMOV: begin
              addr = valc + reg_rd(rb);
              if (!in_range(addr, 8)) begin
                st = y86ie_pkg::ST_ADR; valp = pc0;
              end else begin
                mw = 1; mw_addr = addr; mw_val = reg_rd(ra);
              end
            end
            y86ie_pkg::I_MRMOV: begin
              addr = valc + reg_rd(rb);
              if (!in_range(addr, 8)) begin
                st = y86ie_pkg::ST_ADR; valp = pc0;
              end else begin
                wr = 1; widx = ra; wval = rd_word(addr);
              end
            end
            y86ie_pkg::I_OPQ: begin
              x = reg_rd(ra);
              y = reg_rd(rb);
              case (fn)
                OP_ADD:  r = y + x;
                OP_SUB:  r = y - x;
                OP_AND:  r = y & x;
                default: r = y ^ x;
              endcase
              if (fn == OP_ADD) o = ((~(x ^ y)) & (r ^ y)) >> 63 != 0;
              else if (fn == OP_SUB) o = ((x ^ y) & (r ^ y)) >> 63 != 0;
              else o = 1'b0;
              z = (r == 0);
              s = r[63];
              wr = 1; widx = rb; wval = r;
            end
            y86ie_pkg::I_JXX: if (cc_holds(fn, z, s, o)) valp = valc;
            y86ie_pkg::I_CALL: begin
              addr = rf_m[y86ie_pkg::REG_RSP] - 8;
              if (!in_range(addr, 8)) begin
                st = y86ie_pkg::ST_ADR; valp = pc0;
              end else begin
                mw = 1; mw_addr = addr; mw_val = valp;
                wr = 1; widx = y86ie_pkg::REG_RSP; wval = addr;
                valp = valc;
              end
            end
            y86ie_pkg::I_RET: begin
              addr = rf_m[y86ie_pkg::REG_RSP];
              if (!in_range(addr, 8)) begin
                st = y86ie_pkg::ST_ADR; valp = pc0;
              end else begin
                valp = rd_word(addr);
                wr = 1; widx = y86ie_pkg::REG_RSP; wval = addr + 8;
              end
            end
            y86ie_pkg::I_PUSH: begin
              x = reg_rd(ra);
              addr = rf_m[y86ie_pkg::REG_RSP] - 8;
              if (!in_range(addr, 8)) begin
                st = y86ie_pkg::ST_ADR; valp = pc0;
              end else begin
                mw = 1; mw_addr = addr; mw_val = x;
                wr = 1; widx = y86ie_pkg::REG_RSP; wval = addr;
              end
            end
            y86ie_pkg::I_POP: begin
              addr = rf_m[y86ie_pkg::REG_RSP];
              if (!in_range(addr, 8)) begin
                st = y86ie_pkg::ST_ADR; valp = pc0;
              end else begin
                x = rd_word(addr);
                rsp_w = 1; rsp_new = addr + 8;
                wr = 1;
                if (ra != y86ie_pkg::REG_NONE) begin
                  widx = ra; wval = x;
                end else begin
                  widx = y86ie_pkg::REG_RSP; wval = addr + 8;
                end
              end
            end
            default: ;
          endcase
          // writes to the no-register id are dropped
          if (wr && widx == y86ie_pkg::REG_NONE) begin
            wr = 0; widx = '0; wval = '0;
          end
          if (commit) begin
            if (mw) begin
              for (int k = 0; k < 8; k++) begin
                mem_m[mw_addr[12:0] + 13'(k)] = mw_val[8*k +: 8];
                known_m[mw_addr[12:0] + 13'(k)] = 1'b1;
              end
            end
            if (rsp_w) rf_m[y86ie_pkg::REG_RSP] = rsp_new;
            if (wr) rf_m[widx] = wval;
            pc_m = valp;
          end
        end
      end
      if (commit) begin
        st_m = st; zf_m = z; sf_m = s; of_m = o;
      end
    end
    res.pc = pc0[12:0]; res.icode = ic; res.ifun = fn; res.status = st;
    res.zf = z; res.sf = s; res.of = o; res.wr = wr; res.idx = widx; res.val = wval;
  endfunction

  // ---------------- driving ----------------
  task automatic send_item(input bit kind, input logic [12:0] la, input logic [7:0] lb);
    y86_result_t res;
    y86_predict(kind, la, lb, 1'b1, res);
    pending_q.push_back(res);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    load_address_i <= la;
    load_byte_i <= lb;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic load_byte(input logic [12:0] a, input logic [7:0] v);
    send_item(KIND_LOAD, a, v);
  endtask

  // fill any never-written byte the next step would read, then step
  task automatic step_once();
    y86_result_t dummy;
    bit again;
    do begin
      again = 0;
      touched_q.delete();
      y86_predict(KIND_STEP, '0, '0, 1'b0, dummy);
      foreach (touched_q[i]) begin
        if (!again && !known_m[touched_q[i]]) begin
          load_byte(touched_q[i], 8'($urandom));
          again = 1;
        end
      end
    end while (again);
    send_item(KIND_STEP, 13'($urandom), 8'($urandom));
  endtask

  // write one instruction at the current pc and execute it
  task automatic emit(input logic [3:0] ic, input logic [3:0] fn, input logic [3:0] ra,
                      input logic [3:0] rb, input logic [63:0] valc);
    logic [7:0] bytes [10];
    int len;
    len = ins_len(ic);
    bytes[0] = {ic, fn};
    if (len == 2 || len == 10) bytes[1] = {ra, rb};
    for (int k = 0; k < 8; k++) begin
      if (len == 10) bytes[2 + k] = valc[8*k +: 8];
      if (len == 9) bytes[1 + k] = valc[8*k +: 8];
    end
    for (int k = 0; k < len; k++) load_byte(pc_m[12:0] + 13'(k), bytes[k]);
    step_once();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(5))
      0:       return 64'h7fff_ffff_ffff_ffff;
      1:       return 64'h8000_0000_0000_0000;
      2:       return 64'd0;
      3:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [3:0] any_reg();
    return 4'($urandom_range(15));
  endfunction

  // keep rsp somewhere safe before a stack operation
  task automatic fix_stack();
    if (rf_m[y86ie_pkg::REG_RSP] < 64'(STACK_LO) ||
        rf_m[y86ie_pkg::REG_RSP] > 64'(y86ie_pkg::MEM_BYTES - 8))
      emit(y86ie_pkg::I_IRMOV, 4'd0, any_reg(), y86ie_pkg::REG_RSP,
           64'($urandom_range(5000, 8000)));
  endtask

  function automatic bit ret_safe();
    logic [63:0] sp, v;
    sp = rf_m[y86ie_pkg::REG_RSP];
    if (!in_range(sp, 8)) return 0;
    v = '0;
    for (int k = 7; k >= 0; k--) begin
      if (!known_m[sp[12:0] + 13'(k)]) return 0;
      v = (v << 8) | 64'(mem_m[sp[12:0] + 13'(k)]);
    end
    return v <= 64'(CODE_TOP + 90);
  endfunction

  // one well-formed random instruction
  task automatic random_instr();
    int pick;
    logic [3:0] rb;
    if (pc_m > 64'(CODE_TOP))
      emit(y86ie_pkg::I_JXX, CC_ALW, 4'd0, 4'd0, 64'($urandom_range(0, 3000)));
    // noise: stray data-region loads
    if ($urandom_range(9) == 0)
      load_byte(13'($urandom_range(DATA_LO, y86ie_pkg::MEM_BYTES - 1)), 8'($urandom));
    pick = $urandom_range(99);
    rb = any_reg();
    if (pick < 6) begin
      emit(y86ie_pkg::I_NOP, 4'd0, 4'd0, 4'd0, '0);
    end else if (pick < 18) begin
      emit(y86ie_pkg::I_CMOV, 4'($urandom_range(6)), any_reg(), rb, '0);
    end else if (pick < 30) begin
      emit(y86ie_pkg::I_IRMOV, 4'd0, any_reg(), rb, rand64());
    end else if (pick < 40) begin
      emit(y86ie_pkg::I_RMMOV, 4'd0, any_reg(), rb,
           64'($urandom_range(DATA_LO, y86ie_pkg::MEM_BYTES - 8)) - reg_rd(rb));
    end else if (pick < 50) begin
      emit(y86ie_pkg::I_MRMOV, 4'd0, any_reg(), rb,
           64'($urandom_range(DATA_LO, y86ie_pkg::MEM_BYTES - 8)) - reg_rd(rb));
    end else if (pick < 68) begin
      emit(y86ie_pkg::I_OPQ, 4'($urandom_range(3)), any_reg(), rb, '0);
    end else if (pick < 76) begin
      emit(y86ie_pkg::I_JXX, 4'($urandom_range(6)), 4'd0, 4'd0,
           64'($urandom_range(0, CODE_TOP)));
    end else if (pick < 82) begin
      fix_stack();
      emit(y86ie_pkg::I_CALL, 4'd0, 4'd0, 4'd0, 64'($urandom_range(0, CODE_TOP)));
    end else if (pick < 87) begin
      fix_stack();
      if (ret_safe()) emit(y86ie_pkg::I_RET, 4'd0, 4'd0, 4'd0, '0);
      else emit(y86ie_pkg::I_OPQ, 4'($urandom_range(3)), any_reg(), rb, '0);
    end else if (pick < 93) begin
      fix_stack();
      emit(y86ie_pkg::I_PUSH, 4'd0, any_reg(), rb, '0);
    end else begin
      fix_stack();
      emit(y86ie_pkg::I_POP, 4'd0, any_reg(), rb, '0);
    end
  endtask

  // ---------------- checking ----------------
  function automatic void cmp_field(input string name, input logic [63:0] exp_v,
                                    input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, got_v);
    end
  endfunction

  initial begin
    int hold_cnt;
    y86_result_t e;
    hold_cnt = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result transfer: expected none actual pc %h", $time,
                   instr_pc_o);
        end else begin
          e = pending_q.pop_front();
          cmp_field("instr_pc", 64'(e.pc), 64'(instr_pc_o));
          cmp_field("icode", 64'(e.icode), 64'(icode_o));
          cmp_field("ifun", 64'(e.ifun), 64'(ifun_o));
          cmp_field("status", 64'(e.status), 64'(status_o));
          cmp_field("zero_flag", 64'(e.zf), 64'(zero_flag_o));
          cmp_field("sign_flag", 64'(e.sf), 64'(sign_flag_o));
          cmp_field("overflow_flag", 64'(e.of), 64'(overflow_flag_o));
          cmp_field("reg_written", 64'(e.wr), 64'(reg_written_o));
          cmp_field("reg_index", 64'(e.idx), 64'(reg_index_o));
          cmp_field("reg_value", e.val, reg_value_o);
        end
      end
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_load_extremes();
    load_byte(13'h1fff, 8'hff);
    load_byte(13'h1000, 8'h00);
    load_byte(13'h0aaa, 8'h55);
    load_byte(13'h1555, 8'haa);
  endtask

  task automatic test_directed_ops();
    emit(y86ie_pkg::I_IRMOV, 4'd0, 4'h5, 4'd0, 64'h7fff_ffff_ffff_ffff);
    emit(y86ie_pkg::I_IRMOV, 4'd0, y86ie_pkg::REG_NONE, 4'd3, 64'd1);
    emit(y86ie_pkg::I_OPQ, OP_ADD, 4'd3, 4'd0, '0);           // signed overflow on add
    emit(y86ie_pkg::I_IRMOV, 4'd0, 4'd0, 4'd1, 64'h8000_0000_0000_0000);
    emit(y86ie_pkg::I_OPQ, OP_SUB, 4'd3, 4'd1, '0);           // signed overflow on sub
    emit(y86ie_pkg::I_OPQ, OP_AND, 4'd0, 4'd0, '0);
    emit(y86ie_pkg::I_OPQ, OP_XOR, 4'd3, 4'd3, '0);           // zero result
    for (int f = 0; f <= 6; f++) emit(y86ie_pkg::I_CMOV, 4'(f), 4'd0, 4'd6, '0);
    emit(y86ie_pkg::I_CMOV, CC_ALW, y86ie_pkg::REG_NONE, 4'd7, '0);  // none reads zero
    emit(y86ie_pkg::I_IRMOV, 4'd0, 4'd0, y86ie_pkg::REG_NONE, 64'hdead);  // dropped
    emit(y86ie_pkg::I_JXX, CC_NE, 4'd0, 4'd0, 64'd600);
    emit(y86ie_pkg::I_IRMOV, 4'd0, 4'd0, y86ie_pkg::REG_RSP, 64'd6000);
    emit(y86ie_pkg::I_CALL, 4'd0, 4'd0, 4'd0, 64'd1200);
    emit(y86ie_pkg::I_RET, 4'd0, 4'd0, 4'd0, '0);
    emit(y86ie_pkg::I_PUSH, 4'd0, y86ie_pkg::REG_RSP, 4'd9, '0);  // pushes old rsp
    emit(y86ie_pkg::I_POP, 4'd0, y86ie_pkg::REG_RSP, 4'd2, '0);   // rsp takes loaded value
    emit(y86ie_pkg::I_PUSH, 4'd0, 4'd14, y86ie_pkg::REG_NONE, '0);
    emit(y86ie_pkg::I_POP, 4'd0, y86ie_pkg::REG_NONE, y86ie_pkg::REG_NONE, '0);  // to rsp
    emit(y86ie_pkg::I_RMMOV, 4'd0, 4'd0, 4'd3, 64'd8184);
    emit(y86ie_pkg::I_MRMOV, 4'd0, 4'd9, 4'd3, 64'd8184);
    emit(y86ie_pkg::I_NOP, 4'd0, 4'd0, 4'd0, '0);
  endtask

  task automatic test_random(input int n, input bit with_hold);
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 2) hold_req = 300;
      random_instr();
    end
  endtask

  // the machine stops for good: pick one way, then step and load while stopped
  task automatic test_stop();
    case ($urandom_range(4))
      0: emit(y86ie_pkg::I_HALT, 4'd0, 4'd0, 4'd0, '0);
      1: begin
        load_byte(pc_m[12:0], 8'($urandom_range(8'hc0, 8'hff)));  // bad icode
        step_once();
      end
      2: begin
        load_byte(pc_m[12:0], {y86ie_pkg::I_OPQ, 4'($urandom_range(4, 15))}); // bad ifun
        step_once();
      end
      3: begin
        emit(y86ie_pkg::I_JXX, CC_ALW, 4'd0, 4'd0, 64'(y86ie_pkg::MEM_BYTES - 4));
        emit(y86ie_pkg::I_IRMOV, 4'd0, 4'd0, 4'd1, '0);           // runs off the end
      end
      default: emit(y86ie_pkg::I_MRMOV, 4'd0, 4'd1, 4'd0,
                    64'(y86ie_pkg::MEM_BYTES - 3) - reg_rd(4'd0));
    endcase
    repeat (3) step_once();
    load_byte(13'($urandom), 8'($urandom));
    step_once();
  endtask

  initial begin
    errors = 0; snd_idle = 0; rcv_idle = 0; hold_req = 0;
    foreach (mem_m[i]) begin
      mem_m[i] = '0;
      known_m[i] = 1'b0;
    end
    foreach (rf_m[i]) rf_m[i] = '0;
    pc_m = '0; zf_m = 0; sf_m = 0; of_m = 0; st_m = y86ie_pkg::ST_AOK;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    kind_i <= 1'b0;
    load_address_i <= '0;
    load_byte_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    snd_idle = 26; rcv_idle = 48;
    test_load_extremes();
    test_directed_ops();
    drain();
    test_random(70, 1'b1);
    drain();
    snd_idle = 48; rcv_idle = 26;
    test_random(70, 1'b0);
    drain();
    snd_idle = 0; rcv_idle = 0;
    test_random(70, 1'b1);
    test_stop();

    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
